>>> src/minifloat8_adder_core_macros.svh
// assertion macros for the minifloat adder core
// used by minifloat8_adder_core.sv, no other dependencies
`ifndef MINIFLOAT8_ADDER_CORE_MACROS_SVH
`define MINIFLOAT8_ADDER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mfa_pkg.sv
// constants and helpers for the minifloat adder core
// no dependencies
`timescale 1ns / 1ps

package mfa_pkg;

  localparam int CODE_W = 8;
  localparam int EXP_W  = 3;
  localparam int FRAC_W = 4;
  // operand magnitude in units of 2^-7: (16 + f) << e, at most 12 bits
  localparam int MAG_W  = 12;
  // sum magnitude, one bit more
  localparam int SUM_W  = 13;
  localparam int POS_W  = 4;

  localparam logic [POS_W-1:0] TOP_POS  = POS_W'(SUM_W - 1);
  localparam logic [POS_W-1:0] FRAC_POS = POS_W'(FRAC_W);
  // leading one at this position means biased exponent 8
  localparam logic [POS_W-1:0] OVF_POS  = POS_W'(FRAC_W + (1 << EXP_W));

  localparam logic [CODE_W-2:0] SAT_MAG = '1;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [POS_W-1:0] pos_t;

  // magnitude of one code, implicit one always present
  function automatic mag_t code_mag(input logic [CODE_W-1:0] code);
    mag_t base;
    base = {{(MAG_W - FRAC_W - 1){1'b0}}, 1'b1, code[FRAC_W-1:0]};
    return base << code[FRAC_W +: EXP_W];
  endfunction

  // position of the leading one, zero for a zero input
  function automatic pos_t lead_pos(input sum_t v);
    pos_t p;
    p = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

endpackage

>>> src/minifloat8_adder_core.sv
// Four-stage pipelined adder for 8-bit minifloats (sign, 3-bit exponent with bias 3,
// 4-bit fraction, implicit leading one, no zero code on input). One word is accepted
// every cycle unless the output stalls, and its sum leaves through the four register
// stages (decode, add/subtract, leading-one search, normalise and pack), each of which
// holds one word and moves on whenever the stage after it has room.
// A stall at the output holds the words in place and s_axis_tready falls only once
// every stage is full. The sum is exact before normalisation, the fraction is
// truncated, an exactly zero sum gives 0x00, overflow saturates to 0x7F or 0xFF and
// underflow forces the exponent field to zero.
// depends on mfa_pkg and minifloat8_adder_core_macros.svh
`timescale 1ns / 1ps
`include "minifloat8_adder_core_macros.svh"

module minifloat8_adder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] operand_a, [15:8] operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] sum_value
  output logic [1:0]  m_axis_tuser    // [0] overflow, [1] underflow
);

  // stage enables, each stage moves when empty or when the next one moves
  logic en1, en2, en3, en4;

  // stage 1: operand magnitudes and signs
  logic          v1;
  mfa_pkg::mag_t ma1, mb1;
  logic          sa1, sb1;

  // stage 2: signed sum as magnitude and sign
  logic          v2;
  mfa_pkg::sum_t mag2;
  logic          neg2;
  mfa_pkg::sum_t mag2_next;
  logic          neg2_next;

  // stage 3: leading one found
  logic          v3;
  mfa_pkg::sum_t mag3;
  logic          neg3;
  logic          nz3;
  mfa_pkg::pos_t pos3;

  // stage 4 logic
  mfa_pkg::sum_t                      norm4;
  logic [mfa_pkg::FRAC_W-1:0]         frac4;
  logic [mfa_pkg::EXP_W-1:0]          exp4;
  logic [7:0]                         tdata_next;
  logic [1:0]                         tuser_next;

  assign en4 = !m_axis_tvalid || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ma1 <= mfa_pkg::code_mag(s_axis_tdata[7:0]);
      mb1 <= mfa_pkg::code_mag(s_axis_tdata[15:8]);
      sa1 <= s_axis_tdata[7];
      sb1 <= s_axis_tdata[15];
    end
  end

  always_comb begin
    if (sa1 == sb1) begin
      mag2_next = {1'b0, ma1} + {1'b0, mb1};
      neg2_next = sa1;
    end else if (ma1 >= mb1) begin
      mag2_next = {1'b0, ma1 - mb1};
      neg2_next = sa1;
    end else begin
      mag2_next = {1'b0, mb1 - ma1};
      neg2_next = sb1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mag2 <= mag2_next;
      neg2 <= neg2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mag3 <= mag2;
      neg3 <= neg2;
      nz3  <= |mag2;
      pos3 <= mfa_pkg::lead_pos(mag2);
    end
  end

  // leading one moved to the top bit, fraction sits just below it
  always_comb begin
    norm4 = mag3 << (mfa_pkg::TOP_POS - pos3);
    frac4 = norm4[mfa_pkg::SUM_W-2 -: mfa_pkg::FRAC_W];
    exp4  = mfa_pkg::EXP_W'(pos3 - mfa_pkg::FRAC_POS);
    tdata_next = '0;
    tuser_next = '0;
    if (nz3) begin
      if (pos3 >= mfa_pkg::OVF_POS) begin
        tdata_next = {neg3, mfa_pkg::SAT_MAG};
        tuser_next = 2'b01;
      end else if (pos3 < mfa_pkg::FRAC_POS) begin
        tdata_next = {neg3, {mfa_pkg::EXP_W{1'b0}}, frac4};
        tuser_next = 2'b10;
      end else begin
        tdata_next = {neg3, exp4, frac4};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m_axis_tdata <= tdata_next;
      m_axis_tuser <= tuser_next;
    end
  end

  `MFA_ASSERT_NOW(a_ovf_saturates, clk, rst, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[6:0] == 7'h7F, "overflow without saturated word")
  `MFA_ASSERT_NOW(a_flags_exclusive, clk, rst, m_axis_tvalid,
    !(m_axis_tuser[0] && m_axis_tuser[1]), "overflow and underflow together")
  `MFA_ASSERT_NOW(a_unf_exp_zero, clk, rst, m_axis_tvalid && m_axis_tuser[1],
    m_axis_tdata[6:4] == 3'b000, "underflow with nonzero exponent field")
  `MFA_ASSERT_NEXT(a_full_stall_holds, clk, rst,
    v1 && v2 && v3 && m_axis_tvalid && !m_axis_tready,
    !s_axis_tready || m_axis_tready, "full pipeline took a word while stalled")

endmodule

>>> sim/tb_minifloat8_adder_core.sv
// testbench for minifloat8_adder_core: directed table then shaped random words,
// random gaps on both streams, results checked against typed table values or an in-bench sum predictor
// depends on mfa_pkg and the adder core rtl
`timescale 1ns / 1ps

module tb_minifloat8_adder_core;

  localparam int OVF_BIT      = 0;
  localparam int UNF_BIT      = 1;
  localparam int TOP_EXP      = 7;
  localparam int RANDOM_WORDS = 1550;
  localparam int MAX_WAIT     = 12;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [mfa_pkg::CODE_W-1:0] code_t;

  typedef struct packed {
    code_t sum;
    logic  ovf;
    logic  unf;
  } sum_result_t;

  typedef struct packed {
    code_t       a;
    code_t       b;
    logic        typed;
    sum_result_t res;
  } add_row_t;

  // typed results only for exact zeros, saturation and one-unit underflows
  localparam int N_ROWS = 22;
  localparam add_row_t ADD_ROWS [N_ROWS] = '{
    '{8'h00, 8'h80, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'h7F, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'h0F, 8'h8F, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'h70, 8'hF0, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'h01, 8'h81, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'h7F, 8'h7F, 1'b1, '{8'h7F, 1'b1, 1'b0}},
    '{8'hFF, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{8'h70, 8'h70, 1'b1, '{8'h7F, 1'b1, 1'b0}},
    '{8'hF0, 8'hF0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{8'h7F, 8'h70, 1'b1, '{8'h7F, 1'b1, 1'b0}},
    '{8'h01, 8'h80, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{8'h81, 8'h00, 1'b1, '{8'h80, 1'b0, 1'b1}},
    '{8'h8F, 8'h00, 1'b0, '0},
    '{8'h00, 8'h00, 1'b0, '0},
    '{8'h80, 8'h80, 1'b0, '0},
    '{8'h7F, 8'h00, 1'b0, '0},
    '{8'hFF, 8'h80, 1'b0, '0},
    '{8'h7F, 8'h80, 1'b0, '0},
    '{8'h10, 8'h80, 1'b0, '0},
    '{8'h6F, 8'h6F, 1'b0, '0},
    '{8'h3A, 8'hC5, 1'b0, '0},
    '{8'h55, 8'hAA, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] operand_a, [15:8] operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] sum_value
  logic [1:0]  m_axis_tuser;        // [0] overflow, [1] underflow

  sum_result_t pending_sums[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  minifloat8_adder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // exact sum in units of 2^-7, then normalise with a truncated fraction
  function automatic sum_result_t predict_sum(input code_t a, input code_t b);
    logic [12:0] mag_a;
    logic [12:0] mag_b;
    logic [12:0] mag;
    logic        neg;
    int          lead;
    int          bexp;
    logic [3:0]  frac;
    sum_result_t r;
    mag_a = {8'b0, 1'b1, a[mfa_pkg::FRAC_W-1:0]} << a[6:4];
    mag_b = {8'b0, 1'b1, b[mfa_pkg::FRAC_W-1:0]} << b[6:4];
    r = '0;
    if (a[7] == b[7]) begin
      mag = mag_a + mag_b;
      neg = a[7];
    end else if (mag_a >= mag_b) begin
      mag = mag_a - mag_b;
      neg = a[7];
    end else begin
      mag = mag_b - mag_a;
      neg = b[7];
    end
    if (mag != '0) begin
      lead = 0;
      for (int i = 0; i < 13; i++) begin
        if (mag[i]) lead = i;
      end
      if (lead >= mfa_pkg::FRAC_W) frac = 4'(mag >> (lead - mfa_pkg::FRAC_W));
      else frac = 4'(mag << (mfa_pkg::FRAC_W - lead));
      bexp = lead - mfa_pkg::FRAC_W;
      if (bexp > TOP_EXP) begin
        r.sum = {neg, 7'h7F};
        r.ovf = 1'b1;
      end else if (bexp < 0) begin
        r.sum = {neg, 3'b000, frac};
        r.unf = 1'b1;
      end else begin
        r.sum = {neg, 3'(bexp), frac};
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // valid is only lowered when a gap follows, so back-to-back words stay high
  task automatic send_word(input code_t a, input code_t b, input sum_result_t res);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
    pending_sums.push_back(res);
  endtask

  task automatic check_word(input sum_result_t got);
    sum_result_t want;
    if (pending_sums.size() == 0) begin
      $error("unexpected word: sum_value %h", got.sum);
      mismatch_count++;
    end else begin
      want = pending_sums.pop_front();
      if (got.sum !== want.sum) begin
        $error("sum_value: expected %h, got %h", want.sum, got.sum);
        mismatch_count++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %b, got %b", want.ovf, got.ovf);
        mismatch_count++;
      end
      if (got.unf !== want.unf) begin
        $error("underflow: expected %b, got %b", want.unf, got.unf);
        mismatch_count++;
      end
    end
  endtask

  initial begin : receiver
    int          stall;
    sum_result_t got;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.sum = m_axis_tdata;
      got.ovf = m_axis_tuser[OVF_BIT];
      got.unf = m_axis_tuser[UNF_BIT];
      check_word(got);
    end
  end

  initial begin : stimulus
    code_t a;
    code_t b;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (ADD_ROWS[i]) begin
      send_word(ADD_ROWS[i].a, ADD_ROWS[i].b,
                ADD_ROWS[i].typed ? ADD_ROWS[i].res
                                  : predict_sum(ADD_ROWS[i].a, ADD_ROWS[i].b));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      a = code_t'($urandom);
      b = code_t'($urandom);
      case ($urandom_range(0, 3))
        2: begin
          // near cancellation, reaches zero and underflow
          b = {~a[7], a[6:4] ^ 3'($urandom_range(0, 1)), 4'($urandom)};
        end
        3: begin
          // both large and same sign, reaches saturation
          a[6:4] = 3'($urandom_range(5, 7));
          b = {a[7], 3'($urandom_range(5, 7)), 4'($urandom)};
        end
        default: ;
      endcase
      send_word(a, b, predict_sum(a, b));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
